/* sv/tpad_pkg.sv */
// Shared types, widths, constants and helper functions for the touchpad tracker.
package tpad_pkg;

    // Width of a raw coordinate and the widths that follow from it.
    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int ACC_W      = COORD_BITS + 2;
    localparam int DVD_W      = COORD_BITS + 7;
    localparam int DSR_W      = 12;
    localparam int CNT_W      = $clog2(DVD_W);
    localparam int REM_W      = 7;

    localparam logic [DSR_W-1:0] NOTCH_UNITS = 12'd40;
    localparam logic [DSR_W-1:0] SCALE_MIN   = 12'd16;
    localparam logic [15:0]      SCALE_KNEE  = 16'd80;

    // Notch count by reciprocal: ((mag >> 3) * 0xCCCD) >> 18 equals mag / 40 for
    // every magnitude the scroll accumulator can reach.
    localparam int          NOTCH_PRE   = 3;
    localparam int          NOTCH_SHIFT = 18;
    localparam logic [15:0] NOTCH_RECIP = 16'hCCCD;
    localparam int          NPROD_W     = ACC_W - NOTCH_PRE + 16;
    localparam int          NQ_W        = NPROD_W - NOTCH_SHIFT;

    localparam logic [15:0] RANGE_RESET  = 16'd2047;
    localparam logic [15:0] WINDOW_RESET = 16'd40;
    localparam logic [11:0] SLACK_RESET  = 12'd40;

    typedef enum logic [1:0] {
        CFG_RANGE_X,
        CFG_RANGE_Y,
        CFG_TAP_WINDOW,
        CFG_TAP_SLACK
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_SCROLL,
        KIND_FIRST,
        KIND_MOVE,
        KIND_LIFT
    } kind_t;

    typedef enum logic [1:0] {
        DIV_SCROLL,
        DIV_X,
        DIV_Y
    } div_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_DIV_S,
        ST_DIV_X,
        ST_DIV_Y,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     save_x;
        logic     commit;
    } tpad_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  div_busy;
        logic  zero_rx;
        logic  zero_ry;
        logic  out_free;
    } tpad_stat_t;

    // Magnitude of a signed coordinate difference.
    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] res;
        res = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
        return res;
    endfunction

    // Signed value from sign and magnitude, saturated to 12 bits.
    function automatic logic signed [11:0] sat_delta(input logic neg,
                                                     input logic [DVD_W-1:0] mag);
        logic [11:0] neg_bits;
        logic signed [11:0] res;
        neg_bits = ~mag[11:0] + 12'd1;
        if (neg)
        begin
            res = (mag > DVD_W'(2048)) ? -12'sd2048 : $signed(neg_bits);
        end
        else
        begin
            res = (mag > DVD_W'(2047)) ? 12'sd2047 : $signed(mag[11:0]);
        end
        return res;
    endfunction

    // Signed value from sign and magnitude, saturated to 8 bits.
    function automatic logic signed [7:0] sat_scroll(input logic neg,
                                                     input logic [DVD_W-1:0] mag);
        logic [7:0] neg_bits;
        logic signed [7:0] res;
        neg_bits = ~mag[7:0] + 8'd1;
        if (neg)
        begin
            res = (mag > DVD_W'(128)) ? -8'sd128 : $signed(neg_bits);
        end
        else
        begin
            res = (mag > DVD_W'(127)) ? 8'sd127 : $signed(mag[7:0]);
        end
        return res;
    endfunction

endpackage

/* sv/touchpad_tap_and_scroll_tracker.sv */
// Top level of the touchpad tap and scroll tracker: controller plus datapath.
// Path from request acceptance to result valid: first contact, lift and unscaled motion go
// straight to the result, two-finger scroll passes ST_DIV_S, and motion runs the 23-step
// divider once for each scaled axis. One request is worked at a time and the next is taken
// the cycle after its result is registered; a stalled earlier result holds the block in ST_OUT.
// Reset (rst_n, asynchronous, active low) restores default registers and tracking state.
module touchpad_tap_and_scroll_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        pos_x,
    input  logic [15:0]        pos_y,
    input  logic [1:0]         phys_buttons,
    input  logic [3:0]         finger_count,
    input  logic signed [7:0]  wheel_in,
    input  logic [31:0]        now_tick,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [11:0] delta_x,
    output logic signed [11:0] delta_y,
    output logic [1:0]         buttons_out,
    output logic signed [7:0]  scroll_out
);
    import tpad_pkg::*;

    // The controller only sees a short status word from the datapath and answers
    // with commands: capture the request, start a division on one operand, keep
    // the x quotient, and commit the state update together with the result.
    tpad_cmd_t  cmd;
    tpad_stat_t stat;

    tpad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the tracking state, a reciprocal notch
    // counter for scroll, the divider used for motion scaling, and the result register.
    // The result register lets a finished result wait for the consumer while the next
    // request is taken.
    tpad_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .phys_buttons (phys_buttons),
        .finger_count (finger_count),
        .wheel_in     (wheel_in),
        .now_tick     (now_tick),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .buttons_out  (buttons_out),
        .scroll_out   (scroll_out)
    );

endmodule

/* sv/tpad_div.sv */
// Unsigned restoring divider that retires one quotient bit per cycle.
module tpad_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tpad_pkg::DVD_W-1:0]  dividend,
    input  logic [tpad_pkg::DSR_W-1:0]  divisor,
    output logic                        busy,
    output logic [tpad_pkg::DVD_W-1:0]  quot
);
    import tpad_pkg::*;

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quot_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;

    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   trial_sub;
    logic             trial_ge;

    // The next dividend bit joins the partial remainder; subtract if it fits.
    assign trial     = {rem_reg, quot_reg[DVD_W-1]};
    assign trial_ge  = trial >= {1'b0, dsr_reg};
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DVD_W-2:0], trial_ge};
            rem_reg  <= trial_ge ? trial_sub[DSR_W-1:0] : trial[DSR_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

/* sv/tpad_dpath.sv */
// Datapath: sample and state registers, tap and scroll logic, divider and result register.
module tpad_dpath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tpad_pkg::tpad_cmd_t    cmd,
    output tpad_pkg::tpad_stat_t   stat,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic [15:0]            pos_x,
    input  logic [15:0]            pos_y,
    input  logic [1:0]             phys_buttons,
    input  logic [3:0]             finger_count,
    input  logic signed [7:0]      wheel_in,
    input  logic [31:0]            now_tick,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [11:0]     delta_x,
    output logic signed [11:0]     delta_y,
    output logic [1:0]             buttons_out,
    output logic signed [7:0]      scroll_out
);
    import tpad_pkg::*;

    // Configuration.
    logic [15:0] range_x_reg, range_y_reg, tap_window_reg;
    logic [11:0] tap_slack_reg;

    // Captured sample.
    logic [COORD_BITS-1:0] in_x_reg, in_y_reg;
    logic [1:0]            in_btn_reg;
    logic [3:0]            in_cnt_reg;
    logic signed [7:0]     in_wheel_reg;
    logic [31:0]           in_tick_reg;

    // Tracking state.
    logic                     touching_reg, has_moved_reg, tap_pending_reg, fake_right_reg;
    logic [COORD_BITS-1:0]    prev_x_reg, prev_y_reg, origin_x_reg, origin_y_reg;
    logic [COORD_BITS-1:0]    tap_x_reg, tap_y_reg;
    logic [31:0]              tap_time_reg;
    logic signed [REM_W-1:0]  scroll_rem_reg;

    // Division bookkeeping.
    logic                neg_reg;
    logic signed [11:0]  dx_scaled_reg;

    // Notch count pipeline for two-finger scroll.
    logic [ACC_W-1:0]    acc_mag_reg;
    logic                acc_neg_reg;
    logic [NQ_W-1:0]     notch_q_reg;

    // Result register.
    logic               out_valid_reg;
    logic signed [11:0] dx_out_reg, dy_out_reg;
    logic [1:0]         btn_out_reg;
    logic signed [7:0]  scroll_out_reg;

    logic signed [DIFF_W-1:0] dx_raw, dy_raw, tx_raw, ty_raw, ox_raw, oy_raw;
    logic [DIFF_W-1:0]        dx_mag, dy_mag, tx_mag, ty_mag, ox_mag, oy_mag;
    logic signed [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]         acc_mag;
    logic [NPROD_W-1:0]       notch_prod;
    logic [ACC_W-1:0]         notch_rem;
    logic [DVD_W-1:0]         dx_mag80, dy_mag80;
    logic [DSR_W-1:0]         div_x, div_y;
    logic [DVD_W-1:0]         div_dividend;
    logic [DSR_W-1:0]         div_divisor;
    logic                     div_neg;
    logic                     div_busy;
    logic [DVD_W-1:0]         div_quot;
    logic [31:0]              tick_diff;
    logic                     in_window, tap_near, dbl_tap, tap_arm, moved_far;
    logic [DIFF_W:0]          manhattan;
    logic signed [REM_W-1:0]  rem_signed;
    logic [REM_W-1:0]         rem_neg_bits;
    kind_t                    kind;
    logic                     out_free;
    logic signed [11:0]       dx_res, dy_res;
    logic [1:0]               btn_res;
    logic signed [7:0]        scroll_res;

    assign dx_raw = $signed({1'b0, in_x_reg}) - $signed({1'b0, prev_x_reg});
    assign dy_raw = $signed({1'b0, in_y_reg}) - $signed({1'b0, prev_y_reg});
    assign tx_raw = $signed({1'b0, in_x_reg}) - $signed({1'b0, tap_x_reg});
    assign ty_raw = $signed({1'b0, in_y_reg}) - $signed({1'b0, tap_y_reg});
    assign ox_raw = $signed({1'b0, in_x_reg}) - $signed({1'b0, origin_x_reg});
    assign oy_raw = $signed({1'b0, in_y_reg}) - $signed({1'b0, origin_y_reg});

    assign dx_mag = abs_diff(dx_raw);
    assign dy_mag = abs_diff(dy_raw);
    assign tx_mag = abs_diff(tx_raw);
    assign ty_mag = abs_diff(ty_raw);
    assign ox_mag = abs_diff(ox_raw);
    assign oy_mag = abs_diff(oy_raw);

    // Scroll accumulator: carried remainder plus new vertical travel.
    assign acc     = $signed({{(ACC_W - REM_W){scroll_rem_reg[REM_W-1]}}, scroll_rem_reg})
                   + $signed({dy_raw[DIFF_W-1], dy_raw});
    assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

    // Notch quotient by reciprocal multiplication, remainder by multiply-back.
    assign notch_prod = NPROD_W'(acc_mag_reg[ACC_W-1:NOTCH_PRE]) * NPROD_W'(NOTCH_RECIP);
    assign notch_rem  = acc_mag_reg - ACC_W'(notch_q_reg) * ACC_W'(NOTCH_UNITS);

    // Times 80 as two shifted copies.
    assign dx_mag80 = DVD_W'({dx_mag, 6'b0}) + DVD_W'({dx_mag, 4'b0});
    assign dy_mag80 = DVD_W'({dy_mag, 6'b0}) + DVD_W'({dy_mag, 4'b0});

    assign div_x = (range_x_reg > SCALE_KNEE) ? range_x_reg[15:4] : SCALE_MIN;
    assign div_y = (range_y_reg > SCALE_KNEE) ? range_y_reg[15:4] : SCALE_MIN;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_X:
            begin
                div_dividend = dx_mag80;
                div_divisor  = div_x;
                div_neg      = dx_raw[DIFF_W-1];
            end
            DIV_Y:
            begin
                div_dividend = dy_mag80;
                div_divisor  = div_y;
                div_neg      = dy_raw[DIFF_W-1];
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = NOTCH_UNITS;
                div_neg      = 1'b0;
            end
        endcase
    end

    tpad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    // Classify the captured sample.
    always_comb
    begin
        if (in_wheel_reg == 8'sd0 && in_cnt_reg >= 4'd2 && touching_reg)
        begin
            kind = KIND_SCROLL;
        end
        else if (in_cnt_reg != 4'd0)
        begin
            kind = touching_reg ? KIND_MOVE : KIND_FIRST;
        end
        else
        begin
            kind = KIND_LIFT;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    assign stat.kind     = kind;
    assign stat.div_busy = div_busy;
    assign stat.zero_rx  = (range_x_reg == 16'd0);
    assign stat.zero_ry  = (range_y_reg == 16'd0);
    assign stat.out_free = out_free;

    // A wrapped (negative) tick difference counts as inside the window.
    assign tick_diff = in_tick_reg - tap_time_reg;
    assign in_window = tick_diff[31] || (tick_diff <= {16'b0, tap_window_reg});
    assign tap_near  = (tx_mag < DIFF_W'(tap_slack_reg)) && (ty_mag < DIFF_W'(tap_slack_reg));
    assign dbl_tap   = !in_btn_reg[1] && tap_pending_reg && in_window && tap_near;
    assign tap_arm   = touching_reg && !has_moved_reg && !in_btn_reg[1] && !fake_right_reg;
    assign manhattan = {1'b0, ox_mag} + {1'b0, oy_mag};
    assign moved_far = manhattan > (DIFF_W + 1)'(tap_slack_reg);

    assign rem_neg_bits = ~notch_rem[REM_W-1:0] + REM_W'(1);
    assign rem_signed   = acc_neg_reg ? $signed(rem_neg_bits) : $signed(notch_rem[REM_W-1:0]);

    always_comb
    begin
        dx_res     = 12'sd0;
        dy_res     = 12'sd0;
        btn_res    = in_btn_reg;
        scroll_res = in_wheel_reg;
        case (kind)
            KIND_SCROLL:
            begin
                scroll_res = sat_scroll(acc_neg_reg, DVD_W'(notch_q_reg));
            end
            KIND_FIRST:
            begin
                scroll_res = 8'sd0;
                if (dbl_tap)
                begin
                    btn_res = in_btn_reg | 2'b10;
                end
            end
            KIND_MOVE:
            begin
                dx_res = stat.zero_rx ? sat_delta(dx_raw[DIFF_W-1], DVD_W'(dx_mag))
                                      : dx_scaled_reg;
                dy_res = stat.zero_ry ? sat_delta(dy_raw[DIFF_W-1], DVD_W'(dy_mag))
                                      : sat_delta(neg_reg, div_quot);
                if (fake_right_reg && !in_btn_reg[1])
                begin
                    btn_res = in_btn_reg | 2'b10;
                end
            end
            default:
            begin
                if (!tap_arm && fake_right_reg)
                begin
                    btn_res = {1'b0, in_btn_reg[0]};
                end
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_x_reg    <= RANGE_RESET;
            range_y_reg    <= RANGE_RESET;
            tap_window_reg <= WINDOW_RESET;
            tap_slack_reg  <= SLACK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RANGE_X:    range_x_reg    <= cfg_data;
                CFG_RANGE_Y:    range_y_reg    <= cfg_data;
                CFG_TAP_WINDOW: tap_window_reg <= cfg_data;
                CFG_TAP_SLACK:  tap_slack_reg  <= cfg_data[11:0];
                default:        ;
            endcase
        end
    end

    // Sample capture and division bookkeeping.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_x_reg     <= pos_x[COORD_BITS-1:0];
            in_y_reg     <= pos_y[COORD_BITS-1:0];
            in_btn_reg   <= phys_buttons;
            in_cnt_reg   <= finger_count;
            in_wheel_reg <= wheel_in;
            in_tick_reg  <= now_tick;
        end
        if (cmd.div_start)
        begin
            neg_reg <= div_neg;
        end
        if (cmd.save_x)
        begin
            dx_scaled_reg <= sat_delta(neg_reg, div_quot);
        end
    end

    // The notch pipeline runs every cycle; its operands hold still while a sample is
    // worked, so acc_mag_reg and then notch_q_reg settle before the scroll result commits.
    always_ff @(posedge clk)
    begin
        acc_mag_reg <= acc_mag;
        acc_neg_reg <= acc[ACC_W-1];
        notch_q_reg <= notch_prod[NPROD_W-1:NOTCH_SHIFT];
    end

    // Tracking state, updated once per sample when its result is registered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touching_reg    <= 1'b0;
            has_moved_reg   <= 1'b0;
            tap_pending_reg <= 1'b0;
            fake_right_reg  <= 1'b0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            tap_x_reg       <= '0;
            tap_y_reg       <= '0;
            tap_time_reg    <= '0;
            scroll_rem_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            case (kind)
                KIND_SCROLL:
                begin
                    prev_x_reg      <= in_x_reg;
                    prev_y_reg      <= in_y_reg;
                    scroll_rem_reg  <= rem_signed;
                    tap_pending_reg <= 1'b0;
                    fake_right_reg  <= 1'b0;
                end
                KIND_FIRST:
                begin
                    touching_reg   <= 1'b1;
                    prev_x_reg     <= in_x_reg;
                    prev_y_reg     <= in_y_reg;
                    origin_x_reg   <= in_x_reg;
                    origin_y_reg   <= in_y_reg;
                    has_moved_reg  <= 1'b0;
                    scroll_rem_reg <= '0;
                    fake_right_reg <= dbl_tap;
                    if (dbl_tap)
                    begin
                        tap_pending_reg <= 1'b0;
                    end
                end
                KIND_MOVE:
                begin
                    prev_x_reg <= in_x_reg;
                    prev_y_reg <= in_y_reg;
                    if (moved_far)
                    begin
                        has_moved_reg <= 1'b1;
                    end
                end
                default:
                begin
                    if (tap_arm)
                    begin
                        tap_pending_reg <= 1'b1;
                        tap_x_reg       <= prev_x_reg;
                        tap_y_reg       <= prev_y_reg;
                        tap_time_reg    <= in_tick_reg;
                    end
                    touching_reg   <= 1'b0;
                    scroll_rem_reg <= '0;
                    fake_right_reg <= 1'b0;
                    has_moved_reg  <= 1'b0;
                end
            endcase
        end
    end

    // Result register: holds a finished request until the consumer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            dx_out_reg     <= dx_res;
            dy_out_reg     <= dy_res;
            btn_out_reg    <= btn_res;
            scroll_out_reg <= scroll_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign delta_x     = dx_out_reg;
    assign delta_y     = dy_out_reg;
    assign buttons_out = btn_out_reg;
    assign scroll_out  = scroll_out_reg;

`ifndef SYNTH
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result register not loaded after commit");
`endif

endmodule

/* sv/tpad_ctrl.sv */
// Controller state machine that sequences capture, division steps and result commit.
module tpad_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tpad_pkg::tpad_stat_t  stat,
    output tpad_pkg::tpad_cmd_t   cmd
);
    import tpad_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                unique case (stat.kind)
                    KIND_SCROLL: state_next = ST_DIV_S;
                    KIND_MOVE:
                    begin
                        if (!stat.zero_rx)
                        begin
                            state_next = ST_DIV_X;
                        end
                        else if (!stat.zero_ry)
                        begin
                            state_next = ST_DIV_Y;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                    default:     state_next = ST_OUT;
                endcase
            end
            ST_DIV_S, ST_DIV_Y:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV_X:
            begin
                if (!stat.div_busy)
                begin
                    state_next = stat.zero_ry ? ST_OUT : ST_DIV_Y;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DIV_SCROLL;
        cmd.save_x    = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_CLASS:
            begin
                // Scroll needs no divider: its notch count settles during ST_DIV_S.
                if (stat.kind == KIND_MOVE)
                begin
                    if (!stat.zero_rx)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_X;
                    end
                    else if (!stat.zero_ry)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_Y;
                    end
                end
            end
            ST_DIV_X:
            begin
                cmd.div_sel = DIV_Y;
                if (!stat.div_busy)
                begin
                    cmd.save_x    = 1'b1;
                    cmd.div_start = !stat.zero_ry;
                end
            end
            ST_DIV_S, ST_DIV_Y:
            begin
                cmd.div_sel = DIV_SCROLL;
            end
            ST_OUT:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");
    a_save_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.save_x |-> !stat.div_busy)
        else $error("x quotient saved before division finished");
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free)
        else $error("result committed over an untaken result");
    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request accepted while one is in work");
`endif

endmodule

/* tb/tpad_report_checker.sv */
// Checker for the touchpad tracker: predicts each pointer report and compares the block's output.
`timescale 1ns / 1ps

module tpad_report_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [15:0]        pos_x,
    input  logic [15:0]        pos_y,
    input  logic [1:0]         phys_buttons,
    input  logic [3:0]         finger_count,
    input  logic signed [7:0]  wheel_in,
    input  logic [31:0]        now_tick,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [11:0] delta_x,
    input  logic signed [11:0] delta_y,
    input  logic [1:0]         buttons_out,
    input  logic signed [7:0]  scroll_out,
    output int                 fail_count,
    output int                 pending
);
    import tpad_pkg::*;

    localparam int NOTCH     = 40;
    localparam int GAIN      = 80;
    localparam int SCALE_DIV = 16;
    localparam int KNEE      = 80;

    typedef struct packed {
        logic signed [11:0] dx;
        logic signed [11:0] dy;
        logic [1:0]         btn;
        logic signed [7:0]  scroll;
    } report_t;

    report_t expected_reports[$];
    report_t want;

    // Register copies.
    bit [15:0] range_x_q;
    bit [15:0] range_y_q;
    bit [15:0] window_q;
    bit [11:0] slack_q;

    // Touch, tap and scroll state.
    bit        touching;
    bit        has_moved;
    bit        tap_pending;
    bit        fake_right;
    int        prev_x;
    int        prev_y;
    int        origin_x;
    int        origin_y;
    int        tap_x;
    int        tap_y;
    int        scroll_rem;
    bit [31:0] tap_stamp;

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Motion is scaled by 80 / (span / 16), or by 80 / 16 for a span of at most 80; a span of zero leaves it raw.
    function automatic int scale_motion(input int d, input bit [15:0] span);
        int divisor;
        if (span == 16'd0)
        begin
            return d;
        end
        divisor = (span > KNEE) ? int'(span) / SCALE_DIV : SCALE_DIV;
        return (d * GAIN) / divisor;
    endfunction

    function automatic report_t predict_report(input int x, input int y, input bit [1:0] pb,
                                               input bit [3:0] fingers, input int wheel,
                                               input bit [31:0] now);
        report_t   r;
        bit [1:0]  btn;
        bit [31:0] elapsed;
        bit        in_window;
        int        dx;
        int        dy;
        int        scr;
        int        acc;
        int        tx;
        int        ty;
        int        slack;
        btn   = pb;
        dx    = 0;
        dy    = 0;
        scr   = wheel;
        slack = int'(slack_q);
        if (wheel == 0 && fingers >= 2 && touching)
        begin
            acc         = scroll_rem + (y - prev_y);
            scr         = clamp(acc / NOTCH, -128, 127);
            scroll_rem  = acc % NOTCH;
            prev_x      = x;
            prev_y      = y;
            tap_pending = 1'b0;
            fake_right  = 1'b0;
        end
        else if (fingers >= 1)
        begin
            if (!touching)
            begin
                tx         = x - tap_x;
                ty         = y - tap_y;
                elapsed    = now - tap_stamp;
                in_window  = elapsed[31] || (elapsed <= window_q);
                touching   = 1'b1;
                prev_x     = x;
                prev_y     = y;
                origin_x   = x;
                origin_y   = y;
                has_moved  = 1'b0;
                scroll_rem = 0;
                if (!pb[1] && tap_pending && in_window &&
                    tx > -slack && tx < slack && ty > -slack && ty < slack)
                begin
                    fake_right  = 1'b1;
                    tap_pending = 1'b0;
                    btn[1]      = 1'b1;
                end
                else
                begin
                    fake_right = 1'b0;
                end
                scr = 0;
            end
            else
            begin
                dx     = x - prev_x;
                dy     = y - prev_y;
                prev_x = x;
                prev_y = y;
                if (magnitude(x - origin_x) + magnitude(y - origin_y) > slack)
                begin
                    has_moved = 1'b1;
                end
                dx = clamp(scale_motion(dx, range_x_q), -2048, 2047);
                dy = clamp(scale_motion(dy, range_y_q), -2048, 2047);
                if (fake_right && !pb[1])
                begin
                    btn[1] = 1'b1;
                end
            end
        end
        else
        begin
            if (touching && !has_moved && !pb[1] && !fake_right)
            begin
                tap_pending = 1'b1;
                tap_x       = prev_x;
                tap_y       = prev_y;
                tap_stamp   = now;
            end
            else if (fake_right)
            begin
                btn[1] = 1'b0;
            end
            touching   = 1'b0;
            scroll_rem = 0;
            fake_right = 1'b0;
            has_moved  = 1'b0;
        end
        r.dx     = dx[11:0];
        r.dy     = dy[11:0];
        r.btn    = btn;
        r.scroll = scr[7:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_x_q   = RANGE_RESET;
            range_y_q   = RANGE_RESET;
            window_q    = WINDOW_RESET;
            slack_q     = SLACK_RESET;
            touching    = 1'b0;
            has_moved   = 1'b0;
            tap_pending = 1'b0;
            fake_right  = 1'b0;
            prev_x      = 0;
            prev_y      = 0;
            origin_x    = 0;
            origin_y    = 0;
            tap_x       = 0;
            tap_y       = 0;
            scroll_rem  = 0;
            tap_stamp   = 32'd0;
            expected_reports.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_RANGE_X:    range_x_q = cfg_data;
                    CFG_RANGE_Y:    range_y_q = cfg_data;
                    CFG_TAP_WINDOW: window_q  = cfg_data;
                    CFG_TAP_SLACK:  slack_q   = cfg_data[11:0];
                    default:        ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                expected_reports.push_back(predict_report(pos_x, pos_y, phys_buttons,
                                                          finger_count, wheel_in, now_tick));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("Pointer report with none expected: dx %0d dy %0d buttons %0d scroll %0d",
                           delta_x, delta_y, buttons_out, scroll_out);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (delta_x !== want.dx)
                    begin
                        $error("delta_x: expected %0d, got %0d", want.dx, delta_x);
                        fail_count++;
                    end
                    if (delta_y !== want.dy)
                    begin
                        $error("delta_y: expected %0d, got %0d", want.dy, delta_y);
                        fail_count++;
                    end
                    if (buttons_out !== want.btn)
                    begin
                        $error("buttons_out: expected %0d, got %0d", want.btn, buttons_out);
                        fail_count++;
                    end
                    if (scroll_out !== want.scroll)
                    begin
                        $error("scroll_out: expected %0d, got %0d", want.scroll, scroll_out);
                        fail_count++;
                    end
                end
            end
            pending = expected_reports.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// Top of the touchpad tracker testbench: clock, reset, sample stimulus, report sink and verdict.
`timescale 1ns / 1ps

module tb_top;
    import tpad_pkg::*;

    // Generous bound on the length of a correct run.
    localparam int CYCLE_LIMIT = 600000;
    // Random samples per register setting, and the length of the long output hold-off.
    localparam int PHASE_SAMPLES = 200;
    localparam int HOLD_CYCLES   = 400;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [1:0]         phys_buttons;
    logic [3:0]         finger_count;
    logic signed [7:0]  wheel_in;
    logic [31:0]        now_tick;
    logic               out_valid;
    logic               out_stall;
    logic signed [11:0] delta_x;
    logic signed [11:0] delta_y;
    logic [1:0]         buttons_out;
    logic signed [7:0]  scroll_out;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // Stimulus bookkeeping. The current register values are kept here only to shape
    // the samples (positions inside the pad, tap timing near the window edge).
    int        samples_sent = 0;
    bit [31:0] tick_now     = 32'd1000;
    bit [15:0] cur_rx       = RANGE_RESET;
    bit [15:0] cur_ry       = RANGE_RESET;
    bit [15:0] cur_window   = WINDOW_RESET;
    bit [11:0] cur_slack    = SLACK_RESET;

    // When calm is set neither side inserts idle cycles. hold_request asks the
    // report sink for one long stall so that the block backs up into its input.
    bit calm         = 1'b0;
    bit hold_request = 1'b0;

    touchpad_tap_and_scroll_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .phys_buttons (phys_buttons),
        .finger_count (finger_count),
        .wheel_in     (wheel_in),
        .now_tick     (now_tick),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .buttons_out  (buttons_out),
        .scroll_out   (scroll_out)
    );

    tpad_report_checker report_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .phys_buttons (phys_buttons),
        .finger_count (finger_count),
        .wheel_in     (wheel_in),
        .now_tick     (now_tick),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .buttons_out  (buttons_out),
        .scroll_out   (scroll_out),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // 20 ns clock period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Clamp a coordinate to what the 16-bit position ports can carry.
    function automatic int coord(input int v);
        return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
    endfunction

    // Uniform offset in -m..m.
    function automatic int spread(input int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    // Offer one sample. The gap before it is drawn per request; with a gap of zero
    // valid simply stays high and only the payload changes at the falling edge.
    // Returns at the falling edge after the request was taken.
    task automatic send_sample(input int x, input int y, input bit [1:0] pb,
                               input bit [3:0] fingers, input logic signed [7:0] wheel,
                               input bit [31:0] tick);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pos_x        <= x[15:0];
        pos_y        <= y[15:0];
        phys_buttons <= pb;
        finger_count <= fingers;
        wheel_in     <= wheel;
        now_tick     <= tick;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        samples_sent++;
    endtask

    // Registers are only written with no request in flight: drop valid and wait
    // until the checker holds no outstanding report.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Write all four registers on consecutive cycles. The slack register is 12 bits
    // wide, so its upper data bits carry noise that the block must ignore.
    task automatic write_regs(input bit [15:0] rx, input bit [15:0] ry,
                              input bit [15:0] win, input bit [11:0] slack);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RANGE_X;
        cfg_data  <= rx;
        @(negedge clk);
        cfg_index <= CFG_RANGE_Y;
        cfg_data  <= ry;
        @(negedge clk);
        cfg_index <= CFG_TAP_WINDOW;
        cfg_data  <= win;
        @(negedge clk);
        cfg_index <= CFG_TAP_SLACK;
        cfg_data  <= {4'($urandom), slack};
        @(negedge clk);
        cfg_we     <= 1'b0;
        cur_rx     = rx;
        cur_ry     = ry;
        cur_window = win;
        cur_slack  = slack;
    endtask

    // One random gesture. Most are well-formed touch sequences (taps, double taps,
    // drags, two-finger scrolls) with random content, so that the tap and scroll
    // state machines are exercised in depth; the rest is wheel traffic, raw noise
    // and broken sequences with arbitrary finger counts.
    task automatic random_gesture();
        int        kind;
        int        steps;
        int        k;
        int        x;
        int        y;
        int        span_x;
        int        span_y;
        int        s;
        int        m;
        bit [1:0]  pb;
        bit [1:0]  pb2;
        span_x = (cur_rx == 16'd0) ? 65535 : int'(cur_rx);
        span_y = (cur_ry == 16'd0) ? 65535 : int'(cur_ry);
        s      = int'(cur_slack);
        kind   = $urandom_range(0, 9);
        pb     = ($urandom_range(0, 5) == 0) ? 2'($urandom) : 2'b00;
        x      = int'($urandom_range(0, span_x));
        y      = int'($urandom_range(0, span_y));
        tick_now += $urandom_range(1, 50);
        case (kind)
            0, 1, 2:
            begin
                // A still touch stays within half the slack on each axis, so the lift arms a
                // tap unless a right button, real or synthetic, is held; then a second touch
                // lands near it, early, late or with the tick running backwards.
                send_sample(x, y, pb, 4'd1, 8'sd0, tick_now);
                steps = $urandom_range(0, 2);
                for (k = 0; k < steps; k++)
                begin
                    tick_now += $urandom_range(1, 5);
                    send_sample(coord(x + spread(s / 2)), coord(y + spread(s / 2)), pb, 4'd1,
                                8'sd0, tick_now);
                end
                tick_now += $urandom_range(1, 5);
                send_sample(coord(x + spread(s)), coord(y + spread(s)), pb, 4'd0, 8'sd0,
                            tick_now);
                case ($urandom_range(0, 3))
                    0, 1:    tick_now += $urandom_range(0, cur_window);
                    2:       tick_now += cur_window + $urandom_range(1, 20);
                    default: tick_now -= $urandom_range(1, 1000);
                endcase
                pb2 = ($urandom_range(0, 4) == 0) ? 2'b10 : 2'($urandom_range(0, 1));
                if ($urandom_range(0, 5) == 0)
                begin
                    x = int'($urandom_range(0, span_x));
                end
                else
                begin
                    x = coord(x + spread(s + 2));
                    y = coord(y + spread(s + 2));
                end
                send_sample(x, y, pb2, 4'd1, 8'sd0, tick_now);
                steps = $urandom_range(0, 3);
                for (k = 0; k < steps; k++)
                begin
                    tick_now += $urandom_range(1, 10);
                    x = coord(x + spread(s));
                    y = coord(y + spread(s));
                    pb2 = ($urandom_range(0, 3) == 0) ? 2'($urandom) : pb2;
                    send_sample(x, y, pb2, 4'd1, 8'sd0, tick_now);
                end
                tick_now += $urandom_range(1, 10);
                send_sample(x, y, ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b00, 4'd0,
                            8'sd0, tick_now);
            end
            3, 4:
            begin
                // Drag, now and then with a jump across the whole coordinate space.
                send_sample(x, y, pb, 4'd1, 8'sd0, tick_now);
                steps = $urandom_range(1, 8);
                for (k = 0; k < steps; k++)
                begin
                    tick_now += $urandom_range(1, 10);
                    m = ($urandom_range(0, 9) == 0) ? 65535 : 4 * s + 20;
                    x = coord(x + spread(m));
                    y = coord(y + spread(m));
                    send_sample(x, y, pb, 4'd1, 8'sd0, tick_now);
                end
                tick_now += $urandom_range(1, 10);
                send_sample(x, y, pb, 4'd0, 8'sd0, tick_now);
            end
            5, 6:
            begin
                // Two-finger scroll; the first sample may already carry two fingers.
                send_sample(x, y, pb, 4'($urandom_range(1, 2)), 8'sd0, tick_now);
                steps = $urandom_range(1, 8);
                for (k = 0; k < steps; k++)
                begin
                    tick_now += $urandom_range(1, 10);
                    m = ($urandom_range(0, 9) == 0) ? 30000 : 150;
                    x = coord(x + spread(20));
                    y = coord(y + spread(m));
                    send_sample(x, y, pb, 4'($urandom_range(2, 15)), 8'sd0, tick_now);
                end
                tick_now += $urandom_range(1, 10);
                send_sample(x, y, pb, 4'd0, 8'sd0, tick_now);
            end
            7:
            begin
                // Explicit wheel values with any finger count.
                steps = $urandom_range(1, 4);
                for (k = 0; k < steps; k++)
                begin
                    tick_now += $urandom_range(1, 10);
                    send_sample(coord(x + spread(50)), coord(y + spread(50)), pb,
                                4'($urandom_range(0, 15)), 8'($urandom), tick_now);
                end
            end
            8:
            begin
                // Raw noise on every field, including arbitrary ticks.
                steps = $urandom_range(1, 3);
                for (k = 0; k < steps; k++)
                begin
                    send_sample(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                                2'($urandom), 4'($urandom),
                                ($urandom_range(0, 1) == 0) ? 8'sd0 : 8'($urandom),
                                ($urandom_range(0, 1) == 0) ? $urandom : tick_now);
                end
            end
            default:
            begin
                // Broken sequences: lifts, re-touches and finger changes in any order.
                steps = $urandom_range(1, 5);
                for (k = 0; k < steps; k++)
                begin
                    tick_now += $urandom_range(0, 60);
                    x = coord(x + spread(s));
                    y = coord(y + spread(s));
                    send_sample(x, y, pb, 4'($urandom_range(0, 3)), 8'sd0, tick_now);
                end
            end
        endcase
    endtask

    // Report sink. Before each report a stall length is drawn; once, on request,
    // it holds off for a long stretch while the sender keeps offering samples.
    initial
    begin
        int lag;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                lag          = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else if (calm)
            begin
                lag = 0;
            end
            else
            begin
                lag = $urandom_range(0, 13);
            end
            if (lag > 0)
            begin
                out_stall <= 1'b1;
                repeat (lag) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // Main sequence: reset, directed samples at the reset settings, then random
    // gestures under several register settings, then drain and verdict.
    initial
    begin
        int  phase;
        int  phase_start;
        bit  pressure_done;
        pressure_done = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_RANGE_X;
        cfg_data     = 16'd0;
        in_valid     = 1'b0;
        pos_x        = 16'd0;
        pos_y        = 16'd0;
        phys_buttons = 2'b00;
        finger_count = 4'd0;
        wheel_in     = 8'sd0;
        now_tick     = 32'd0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Lift straight after reset: the report carries the wheel value unchanged.
        send_sample(0, 0, 2'b00, 4'd0, -8'sd128, 32'd1000);
        // First contact at the origin, then jumps to both corners: motion saturates.
        send_sample(0, 0, 2'b00, 4'd1, 8'sd0, 32'd1001);
        send_sample(65535, 65535, 2'b00, 4'd1, 8'sd127, 32'd1002);
        send_sample(0, 0, 2'b00, 4'd1, 8'sd0, 32'd1003);
        // Two-finger scroll far down and far up: notch count saturates both ways,
        // and the second leaves a negative remainder.
        send_sample(0, 65535, 2'b11, 4'd2, 8'sd0, 32'd1004);
        send_sample(0, 7, 2'b00, 4'd3, 8'sd0, 32'd1005);
        // Many fingers but a wheel value: plain motion with the wheel passed through.
        send_sample(5, 7, 2'b01, 4'd15, -8'sd1, 32'd1006);
        send_sample(5, 7, 2'b11, 4'd0, 8'sd0, 32'd1007);
        // Still tap, then a second touch inside window and slack: synthetic right
        // button held through motion, dropped on lift.
        send_sample(500, 500, 2'b00, 4'd1, 8'sd0, 32'd1010);
        send_sample(503, 498, 2'b00, 4'd1, 8'sd0, 32'd1012);
        send_sample(503, 498, 2'b00, 4'd0, 8'sd0, 32'd1015);
        send_sample(520, 480, 2'b00, 4'd1, 8'sd0, 32'd1040);
        send_sample(530, 480, 2'b00, 4'd1, 8'sd0, 32'd1041);
        send_sample(530, 480, 2'b01, 4'd1, 8'sd0, 32'd1042);
        send_sample(530, 480, 2'b00, 4'd0, 8'sd0, 32'd1043);
        // Tap, then a second touch one tick past the window: no synthetic button.
        send_sample(100, 100, 2'b00, 4'd1, 8'sd0, 32'd1100);
        send_sample(100, 100, 2'b00, 4'd0, 8'sd0, 32'd1101);
        send_sample(100, 100, 2'b00, 4'd1, 8'sd0, 32'd1142);
        send_sample(100, 100, 2'b00, 4'd0, 8'sd0, 32'd1143);
        // Second touch with a tick before the tap: a negative difference counts as
        // inside the window.
        send_sample(120, 100, 2'b00, 4'd1, 8'sd0, 32'd1050);
        send_sample(120, 100, 2'b00, 4'd0, 8'sd0, 32'd1060);
        // Physical right button on the second touch blocks the double tap.
        send_sample(120, 100, 2'b00, 4'd1, 8'sd0, 32'd1200);
        send_sample(120, 100, 2'b00, 4'd0, 8'sd0, 32'd1201);
        send_sample(121, 100, 2'b10, 4'd1, 8'sd0, 32'd1202);
        send_sample(121, 100, 2'b00, 4'd0, 8'sd0, 32'd1203);
        // Second touch exactly one slack away: outside the match.
        send_sample(161, 100, 2'b00, 4'd1, 8'sd0, 32'd1204);
        send_sample(161, 100, 2'b00, 4'd0, 8'sd0, 32'd1205);

        tick_now = $urandom;
        for (phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            case (phase)
                0: write_regs(RANGE_RESET, RANGE_RESET, WINDOW_RESET, SLACK_RESET);
                1: write_regs(16'd1, 16'd1, 16'd0, 12'd1);
                2: write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF);
                // Zero ranges leave the deltas unscaled.
                3: write_regs(16'd0, 16'd0, 16'd300, 12'd100);
                // Around the knee where the divisor switches to a fixed 16.
                4: write_regs(16'd80, 16'd81, 16'd16, 12'd8);
                default:
                begin
                    write_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                               16'($urandom_range(0, 200)), 12'($urandom_range(1, 300)));
                    // Let the tick counter wrap during this setting.
                    tick_now = 32'hFFFF_FE00;
                end
            endcase
            phase_start = samples_sent;
            while (samples_sent - phase_start < PHASE_SAMPLES)
            begin
                calm = (phase == 2) && (samples_sent - phase_start < 80);
                if (phase == 0 && !pressure_done && samples_sent - phase_start >= 40)
                begin
                    hold_request  = 1'b1;
                    pressure_done = 1'b1;
                end
                random_gesture();
            end
            calm = 1'b0;
        end

        wait_idle();
        repeat (60) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/tpad_pkg.sv
sv/tpad_div.sv
sv/tpad_dpath.sv
sv/tpad_ctrl.sv
sv/touchpad_tap_and_scroll_tracker.sv
tb/tpad_report_checker.sv
tb/tb_top.sv
